/* rtl/per_flow_token_bucket_policer_assert.svh */
// Assertion macros for the flow policer.
// Included by the RTL files that carry concurrent checks.
`ifndef PER_FLOW_TOKEN_BUCKET_POLICER_ASSERT_SVH
`define PER_FLOW_TOKEN_BUCKET_POLICER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PFTB_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pftb check failed");

// Next-cycle implication outside reset.
`define PFTB_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pftb check failed");

`endif

/* rtl/pftb_pkg.sv */
// Shared types and constants for the per-flow token bucket policer.
// No dependencies.
`default_nettype none
package pftb_pkg;
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int KEY_BITS_DEF = 32;
    localparam int TIME_BITS_DEF = 48;
    localparam int TOK_BITS = 36;
    localparam logic [19:0] MICRO = 20'd1000000;
    localparam logic [9:0] MIN_REFILL = 10'd1000;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_RATE = 2'd1;
    localparam logic [1:0] CFG_BURST = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [31:0] flow_key;
        logic [47:0] now_ms;
        logic [31:0] rate;
        logic [15:0] burst;
        logic [15:0] max_age_s;
    } req_t;

    typedef struct packed {
        logic       allowed;
        logic       hit;
        logic       evicted;
        logic [6:0] removed_count;
        logic [6:0] occupancy;
    } rsp_t;
endpackage
`default_nettype wire

/* rtl/per_flow_token_bucket_policer.sv */
// Top level of the per-flow token bucket policer: flow table memory and scan control.
// Depends on pftb_pkg, pftb_bucket and per_flow_token_bucket_policer_assert.svh.
//
//  channel | signals                          | direction
//  req     | req_valid, req_stall, req_data   | in
//  rsp     | rsp_valid, rsp_stall, rsp_data   | out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// A hit passes from accept to response through a scan of every entry, decide, the
// bucket unit and a write-back; a new flow also allocates a slot before the bucket unit.
// Cleanup scans every entry and decides; a request while disabled is answered
// straight from idle. Reset clears valid bits and counters at once.
// A new request is taken only after the previous response has been taken.
`default_nettype none
module per_flow_token_bucket_policer
    import pftb_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   req_valid,
    output logic        req_stall,
    input  wire req_t   req_data,
    output logic        rsp_valid,
    input  wire logic   rsp_stall,
    output rsp_t        rsp_data,
    input  wire logic   cfg_valid,
    output logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import pftb_pkg::*;
    `include "per_flow_token_bucket_policer_assert.svh"

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = IW + 1;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [35:0]          tokens;
        logic [TIME_BITS-1:0] last_refill;
        logic [TIME_BITS-1:0] last_access;
        logic [31:0]          rate;
        logic [15:0]          capacity;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_LAST, S_DECIDE, S_BUCKET, S_WAIT, S_WRITE, S_RESP
    } state_t;

    entry_t                mem [TABLE_ENTRIES];
    entry_t                rd_reg;
    logic [IW-1:0]         rd_addr;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    entry_t                wr_data;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [CW-1:0]         count_reg, count_next;
    state_t                state_reg, state_next;
    req_t                  req_reg, req_next;
    logic [CW-1:0]         scan_reg, scan_next;
    logic [IW-1:0]         prev_reg, prev_next;
    logic                  found_reg, found_next;
    logic [IW-1:0]         slot_reg, slot_next;
    logic                  have_reg, have_next;
    logic [IW-1:0]         lru_reg, lru_next;
    logic [TIME_BITS-1:0]  lru_t_reg, lru_t_next;
    logic [CW-1:0]         removed_reg, removed_next;
    entry_t                ent_reg, ent_next;
    logic                  enable_reg;
    logic [31:0]           drate_reg;
    logic [15:0]           dburst_reg;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  b_start;
    logic                  b_done;
    logic                  b_allowed;
    logic [35:0]           b_tokens;
    logic [TIME_BITS-1:0]  b_refill;

    logic [KEY_BITS-1:0]   key_in;
    logic [TIME_BITS-1:0]  now_in;
    logic [TIME_BITS-1:0]  age;
    logic [TIME_BITS-1:0]  thresh;
    logic                  free_found;
    logic [IW-1:0]         free_idx;

    assign key_in = KEY_BITS'(req_reg.flow_key);
    assign now_in = TIME_BITS'(req_reg.now_ms);
    assign age = now_in - rd_reg.last_access;
    assign thresh = TIME_BITS'(req_reg.max_age_s * 26'd1000);

    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    pftb_bucket #(.TIME_BITS(TIME_BITS)) u_bucket (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (b_start),
        .now         (now_in),
        .last_refill (ent_reg.last_refill),
        .tokens      (ent_reg.tokens),
        .rate        (ent_reg.rate),
        .capacity    (ent_reg.capacity),
        .done        (b_done),
        .allowed     (b_allowed),
        .tokens_out  (b_tokens),
        .refill_out  (b_refill)
    );

    assign req_stall = (state_reg != S_IDLE) || rsp_valid_reg;
    assign cfg_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        req_next = req_reg;
        scan_next = scan_reg;
        prev_next = prev_reg;
        found_next = found_reg;
        slot_next = slot_reg;
        have_next = have_reg;
        lru_next = lru_reg;
        lru_t_next = lru_t_reg;
        removed_next = removed_reg;
        ent_next = ent_reg;
        valid_next = valid_reg;
        count_next = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next = rsp_reg;
        rd_addr = scan_reg[IW-1:0];
        wr_en = 1'b0;
        wr_addr = slot_reg;
        wr_data = ent_reg;
        b_start = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && !rsp_valid_reg)
                begin
                    req_next = req_data;
                    scan_next = '0;
                    found_next = 1'b0;
                    have_next = 1'b0;
                    removed_next = '0;
                    if (!req_data.req_type && !enable_reg)
                    begin
                        rsp_next = '{1'b1, 1'b0, 1'b0, 7'd0, 7'(count_reg)};
                        rsp_valid_next = 1'b1;
                    end
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN, S_LAST:
            begin
                if (state_reg == S_SCAN)
                begin
                    rd_addr = scan_reg[IW-1:0];
                    prev_next = scan_reg[IW-1:0];
                    scan_next = scan_reg + 1'b1;
                    if (scan_reg == CW'(TABLE_ENTRIES - 1))
                        state_next = S_LAST;
                end
                else
                    state_next = S_DECIDE;
                if (scan_reg != '0)
                begin
                    if (valid_reg[prev_reg])
                    begin
                        if (req_reg.req_type)
                        begin
                            if (age >= thresh)
                            begin
                                valid_next[prev_reg] = 1'b0;
                                count_next = count_next - 1'b1;
                                removed_next = removed_next + 1'b1;
                            end
                        end
                        else
                        begin
                            if (!found_reg && rd_reg.key == key_in)
                            begin
                                found_next = 1'b1;
                                slot_next = prev_reg;
                                ent_next = rd_reg;
                            end
                            if (!have_reg || rd_reg.last_access < lru_t_reg)
                            begin
                                have_next = 1'b1;
                                lru_next = prev_reg;
                                lru_t_next = rd_reg.last_access;
                            end
                        end
                    end
                end
            end
            S_DECIDE:
            begin
                if (req_reg.req_type)
                begin
                    rsp_next = '{1'b1, 1'b0, 1'b0, 7'(removed_reg), 7'(count_reg)};
                    state_next = S_RESP;
                end
                else if (found_reg)
                begin
                    ent_next.last_access = now_in;
                    b_start = 1'b1;
                    state_next = S_WAIT;
                    rsp_next = '{1'b0, 1'b1, 1'b0, 7'd0, 7'(count_reg)};
                end
                else
                begin
                    rsp_next = '{1'b1, 1'b0, 1'b0, 7'd0, 7'(count_reg)};
                    if (count_reg >= CW'(TABLE_ENTRIES) && have_reg)
                    begin
                        valid_next[lru_reg] = 1'b0;
                        count_next = count_reg - 1'b1;
                        rsp_next.evicted = 1'b1;
                        rsp_next.occupancy = 7'(count_next);
                    end
                    state_next = S_BUCKET;
                end
            end
            S_BUCKET:
            begin
                if (free_found)
                begin
                    slot_next = free_idx;
                    valid_next[free_idx] = 1'b1;
                    count_next = count_reg + 1'b1;
                    rsp_next.occupancy = 7'(count_next);
                    ent_next.key = key_in;
                    ent_next.rate = (req_reg.rate != 32'd0) ? req_reg.rate : drate_reg;
                    ent_next.capacity = (req_reg.burst != 16'd0) ? req_reg.burst
                                                                  : dburst_reg;
                    ent_next.tokens = 36'(ent_next.capacity) * 36'(MICRO);
                    ent_next.last_refill = now_in;
                    ent_next.last_access = now_in;
                    state_next = S_WAIT;
                end
                else
                    state_next = S_RESP;
            end
            S_WAIT:
            begin
                if (!b_done && ent_reg.last_access == now_in && !found_reg
                    && ent_reg.key == key_in && rsp_reg.hit == 1'b0 && scan_reg != '0)
                begin
                    b_start = 1'b1;
                    scan_next = '0;
                end
                if (b_done)
                begin
                    ent_next.tokens = b_tokens;
                    ent_next.last_refill = b_refill;
                    rsp_next.allowed = b_allowed;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                wr_en = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                rsp_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
            rsp_valid_reg <= 1'b0;
            scan_reg <= '0;
            enable_reg <= 1'b1;
            drate_reg <= 32'd10000;
            dburst_reg <= 16'd20;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            scan_reg <= scan_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ENABLE: enable_reg <= cfg_data[0];
                    CFG_RATE:   drate_reg <= cfg_data;
                    CFG_BURST:  dburst_reg <= cfg_data[15:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        prev_reg <= prev_next;
        found_reg <= found_next;
        slot_reg <= slot_next;
        have_reg <= have_next;
        lru_reg <= lru_next;
        lru_t_reg <= lru_t_next;
        removed_reg <= removed_next;
        ent_reg <= ent_next;
        rsp_reg <= rsp_next;
    end

    `PFTB_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= CW'(TABLE_ENTRIES))
    `PFTB_ASSERT_IMP(a_count_match, clk, rst_n, state_reg == S_IDLE,
                     count_reg == CW'($countones(valid_reg)))
    `PFTB_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, req_stall)
    `PFTB_ASSERT_NEXT(a_write_resp, clk, rst_n, state_reg == S_WRITE, state_reg == S_RESP)
endmodule
`default_nettype wire

/* rtl/pftb_bucket.sv */
// Token refill and spend arithmetic, stepped through multiply, cap, add and spend states.
// Depends on pftb_pkg.
`default_nettype none
module pftb_bucket #(
    parameter int TIME_BITS = 48
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [TIME_BITS-1:0]  now,
    input  wire logic [TIME_BITS-1:0]  last_refill,
    input  wire logic [35:0]           tokens,
    input  wire logic [31:0]           rate,
    input  wire logic [15:0]           capacity,
    output logic                       done,
    output logic                       allowed,
    output logic [35:0]                tokens_out,
    output logic [TIME_BITS-1:0]       refill_out
);
    import pftb_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_MUL, B_CAP, B_ADD, B_SPEND} bstate_t;

    bstate_t               state_reg, state_next;
    logic [TIME_BITS-1:0]  el_reg, el_next;
    logic                  fwd_reg, fwd_next;
    logic [63:0]           lo_reg, lo_next;
    logic [63:0]           hi_reg, hi_next;
    logic [35:0]           cap_reg, cap_next;
    logic                  sat_reg, sat_next;
    logic [35:0]           tok_reg, tok_next;
    logic [TIME_BITS-1:0]  rf_reg, rf_next;
    logic                  done_reg, done_next;
    logic                  alw_reg, alw_next;
    logic [63:0]           el_lo;
    logic [63:0]           el_hi;
    logic [64:0]           add_full;
    logic [35:0]           room;

    always_comb
    begin
        el_lo = {32'd0, el_reg[31:0]};
        el_hi = 64'(el_reg >> 32);
        add_full = {1'b0, lo_reg} + {1'b0, hi_reg[31:0], 32'd0};
        room = cap_reg - tok_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        el_next = el_reg;
        fwd_next = fwd_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        cap_next = cap_reg;
        sat_next = sat_reg;
        tok_next = tok_reg;
        rf_next = rf_reg;
        done_next = 1'b0;
        alw_next = alw_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    fwd_next = now > last_refill;
                    el_next = now - last_refill;
                    tok_next = tokens;
                    rf_next = last_refill;
                    cap_next = 36'(capacity) * 36'(MICRO);
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                lo_next = el_lo[31:0] * rate;
                hi_next = el_hi[31:0] * rate;
                state_next = B_CAP;
            end
            B_CAP:
            begin
                sat_next = (hi_reg[63:32] != 32'd0) || add_full[64];
                lo_next = add_full[63:0];
                state_next = B_ADD;
            end
            B_ADD:
            begin
                if (fwd_reg && (sat_reg || lo_reg >= 64'(MIN_REFILL)))
                begin
                    rf_next = now;
                    if (tok_reg >= cap_reg || sat_reg || lo_reg >= 64'(room))
                        tok_next = cap_reg;
                    else
                        tok_next = tok_reg + lo_reg[35:0];
                end
                state_next = B_SPEND;
            end
            B_SPEND:
            begin
                alw_next = tok_reg >= 36'(MICRO);
                if (tok_reg >= 36'(MICRO))
                    tok_next = tok_reg - 36'(MICRO);
                done_next = 1'b1;
                state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        el_reg <= el_next;
        fwd_reg <= fwd_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        cap_reg <= cap_next;
        sat_reg <= sat_next;
        tok_reg <= tok_next;
        rf_reg <= rf_next;
        alw_reg <= alw_next;
    end

    assign done = done_reg;
    assign allowed = alw_reg;
    assign tokens_out = tok_reg;
    assign refill_out = rf_reg;
endmodule
`default_nettype wire

/* test/per_flow_token_bucket_policer_checker.sv */
// Checker for the per-flow token bucket policer: watches the request, response and
// register channels, predicts every response and compares it field by field.
// Depends on pftb_pkg.
module per_flow_token_bucket_policer_checker
    import pftb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  req_t        req_data,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  rsp_t        rsp_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    localparam int NENT = 64;

    logic        en;
    logic [31:0] def_rate;
    logic [15:0] def_burst;

    logic        ent_valid [NENT];
    logic [31:0] ent_key   [NENT];
    logic [63:0] ent_tokens[NENT];
    logic [47:0] ent_refill[NENT];
    logic [47:0] ent_access[NENT];
    logic [31:0] ent_rate  [NENT];
    logic [15:0] ent_cap   [NENT];
    int          live;

    rsp_t expected_rsps[$];

    initial fail_count = 0;
    assign pending = expected_rsps.size();

    task automatic report(string field, logic [6:0] got, logic [6:0] want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        fail_count++;
    endtask

    function automatic void refill_bucket(int i, logic [47:0] now);
        logic [63:0] cap;
        logic [47:0] elapsed;
        logic [79:0] prod;
        logic [63:0] add;
        cap = 64'(ent_cap[i]) * 64'd1000000;
        if (now <= ent_refill[i])
            return;
        elapsed = now - ent_refill[i];
        prod = 80'(elapsed) * 80'(ent_rate[i]);
        add = (prod[79:64] != 0) ? {64{1'b1}} : prod[63:0];
        if (add < 64'(MIN_REFILL))
            return;
        if (ent_tokens[i] >= cap || add >= cap - ent_tokens[i])
            ent_tokens[i] = cap;
        else
            ent_tokens[i] = ent_tokens[i] + add;
        ent_refill[i] = now;
    endfunction

    function automatic logic spend_token(int i, logic [47:0] now);
        refill_bucket(i, now);
        if (ent_tokens[i] >= 64'(MICRO))
        begin
            ent_tokens[i] = ent_tokens[i] - 64'(MICRO);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic rsp_t police(req_t r);
        rsp_t        o;
        logic [47:0] threshold;
        int          slot;
        int          lru;
        bit          have;
        o = '0;
        o.allowed = 1'b1;
        threshold = 48'(r.max_age_s) * 48'd1000;
        slot = -1;
        if (r.req_type)
        begin
            for (int i = 0; i < NENT; i++)
                if (ent_valid[i] && (r.now_ms - ent_access[i]) >= threshold)
                begin
                    ent_valid[i] = 1'b0;
                    live--;
                    o.removed_count++;
                end
        end
        else if (en)
        begin
            for (int i = 0; i < NENT; i++)
                if (slot < 0 && ent_valid[i] && ent_key[i] == r.flow_key)
                    slot = i;
            if (slot >= 0)
            begin
                o.hit = 1'b1;
                ent_access[slot] = r.now_ms;
                o.allowed = spend_token(slot, r.now_ms);
            end
            else
            begin
                if (live >= NENT)
                begin
                    have = 0;
                    lru = 0;
                    for (int i = 0; i < NENT; i++)
                        if (ent_valid[i] && (!have || ent_access[i] < ent_access[lru]))
                        begin
                            lru = i;
                            have = 1;
                        end
                    if (have)
                    begin
                        ent_valid[lru] = 1'b0;
                        live--;
                        o.evicted = 1'b1;
                    end
                end
                for (int i = 0; i < NENT; i++)
                    if (slot < 0 && !ent_valid[i])
                        slot = i;
                if (slot >= 0)
                begin
                    ent_valid[slot] = 1'b1;
                    live++;
                    ent_key[slot] = r.flow_key;
                    ent_rate[slot] = (r.rate != 0) ? r.rate : def_rate;
                    ent_cap[slot] = (r.burst != 0) ? r.burst : def_burst;
                    ent_tokens[slot] = 64'(ent_cap[slot]) * 64'd1000000;
                    ent_refill[slot] = r.now_ms;
                    ent_access[slot] = r.now_ms;
                    o.allowed = spend_token(slot, r.now_ms);
                end
            end
        end
        o.occupancy = 7'(live);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            en = 1'b1;
            def_rate = 32'd10000;
            def_burst = 16'd20;
            live = 0;
            for (int i = 0; i < NENT; i++)
                ent_valid[i] = 1'b0;
            expected_rsps.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_ENABLE: en = cfg_data[0];
                    CFG_RATE:   def_rate = cfg_data;
                    CFG_BURST:  def_burst = cfg_data[15:0];
                    default: ;
                endcase
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("unexpected response at %0t", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp_data.allowed !== want.allowed)
                        report("allowed", 7'(rsp_data.allowed), 7'(want.allowed));
                    if (rsp_data.hit !== want.hit)
                        report("hit", 7'(rsp_data.hit), 7'(want.hit));
                    if (rsp_data.evicted !== want.evicted)
                        report("evicted", 7'(rsp_data.evicted), 7'(want.evicted));
                    if (rsp_data.removed_count !== want.removed_count)
                        report("removed_count", rsp_data.removed_count, want.removed_count);
                    if (rsp_data.occupancy !== want.occupancy)
                        report("occupancy", rsp_data.occupancy, want.occupancy);
                end
            end
            if (req_valid && !req_stall)
                expected_rsps.push_back(police(req_data));
        end
    end
endmodule

/* test/per_flow_token_bucket_policer_test.sv */
// Top of the policer testbench: clock, reset, request and register stimulus,
// random response stalls and the verdict. Depends on pftb_pkg, the policer
// and per_flow_token_bucket_policer_checker.
module per_flow_token_bucket_policer_test;
    import pftb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req_data;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycles;
    int          stall_left;
    logic [47:0] clock_ms;

    per_flow_token_bucket_policer u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    per_flow_token_bucket_policer_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left <= 0;
            cycles <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (cycles > 2000000)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                stall_left <= pick_gap();
            end
        end
    end

    function automatic req_t mk(logic kind, logic [31:0] key, logic [47:0] now,
                                logic [31:0] rate, logic [15:0] burst, logic [15:0] age);
        req_t r;
        r.req_type = kind;
        r.flow_key = key;
        r.now_ms = now;
        r.rate = rate;
        r.burst = burst;
        r.max_age_s = age;
        return r;
    endfunction

    task automatic send(req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic req_t random_req();
        req_t r;
        int   p;
        p = $urandom_range(0, 99);
        if (p < 5)
            clock_ms = 48'({$urandom, $urandom});
        else if (p < 8)
            clock_ms = clock_ms - 48'($urandom_range(1, 500));
        else
            clock_ms = clock_ms + 48'($urandom_range(0, 300));
        r.req_type = ($urandom_range(0, 99) < 4);
        r.flow_key = ($urandom_range(0, 9) == 0) ? $urandom : 32'h100 + $urandom_range(0, 79);
        r.now_ms = clock_ms;
        p = $urandom_range(0, 9);
        r.rate = (p < 4) ? 32'd0 : (p < 8) ? $urandom_range(1, 5000) : $urandom;
        p = $urandom_range(0, 9);
        r.burst = (p < 4) ? 16'd0 : (p < 8) ? 16'($urandom_range(1, 5))
                                            : 16'($urandom_range(0, 65535));
        p = $urandom_range(0, 9);
        r.max_age_s = (p < 6) ? 16'($urandom_range(0, 2)) : (p < 8) ? 16'hFFFF
                                                                    : 16'($urandom_range(0, 65535));
        return r;
    endfunction

    task automatic directed_set();
        send(mk(1'b0, 32'd1, 48'd1000, 32'd0, 16'd0, 16'd0));
        send(mk(1'b0, 32'd2, 48'd1000, 32'd0, 16'd1, 16'd0));
        send(mk(1'b0, 32'd2, 48'd1000, 32'd0, 16'd0, 16'd0));
        send(mk(1'b0, 32'd2, 48'd1050, 32'd0, 16'd0, 16'd0));
        send(mk(1'b0, 32'd2, 48'd1050, 32'd0, 16'd0, 16'd0));
        send(mk(1'b0, 32'd2, 48'd1100, 32'd0, 16'd0, 16'd0));
        send(mk(1'b0, 32'd3, 48'd2000, 32'd1, 16'd1, 16'd0));
        send(mk(1'b0, 32'd3, 48'd2500, 32'd1, 16'd0, 16'd0));
        send(mk(1'b0, 32'd3, 48'd100, 32'd0, 16'd0, 16'd0));
        send(mk(1'b0, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF));
        send(mk(1'b0, 32'hFFFFFFFF, 48'd0, 32'd0, 16'd0, 16'd0));
        send(mk(1'b0, 32'd4, 48'd0, 32'hFFFFFFFF, 16'd1, 16'd0));
        send(mk(1'b0, 32'd4, 48'd0, 32'd0, 16'd0, 16'd0));
        send(mk(1'b0, 32'd4, 48'hFFFFFFFFFFFF, 32'd0, 16'd0, 16'd0));
        send(mk(1'b1, 32'd0, 48'd3000, 32'd0, 16'd0, 16'hFFFF));
        send(mk(1'b1, 32'd0, 48'd3000, 32'd0, 16'd0, 16'd1));
        send(mk(1'b1, 32'hFFFFFFFF, 48'd3000, 32'hFFFFFFFF, 16'hFFFF, 16'd0));
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ENABLE;
        cfg_data = '0;
        clock_ms = 48'd5000;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_set();
        wait_idle();
        cfg_write(CFG_RATE, 32'd1);
        cfg_write(CFG_BURST, 32'd1);
        directed_set();
        wait_idle();
        cfg_write(CFG_ENABLE, 32'd0);
        send(mk(1'b0, 32'd9, 48'd4000, 32'd0, 16'd0, 16'd0));
        send(mk(1'b0, 32'd1, 48'd4000, 32'd0, 16'd0, 16'd0));
        send(mk(1'b1, 32'd0, 48'd4000, 32'd0, 16'd0, 16'd0));
        wait_idle();
        cfg_write(CFG_ENABLE, 32'd1);
        cfg_write(CFG_RATE, 32'hFFFFFFFF);
        cfg_write(CFG_BURST, 32'd65535);
        for (int i = 0; i < 70; i++)
            send(mk(1'b0, 32'h200 + i, clock_ms, 32'd0, 16'd0, 16'd0));
        for (int i = 0; i < 150; i++)
            send(random_req());
        wait_idle();
        cfg_write(CFG_RATE, 32'd10000);
        cfg_write(CFG_BURST, 32'd20);
        for (int i = 0; i < 400; i++)
            send(random_req());
        wait_idle();
        for (int i = 0; i < 400; i++)
            send(random_req());

        wait_idle();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
